[design/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// shared widths, constants and the job record passed from front to back
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int VALUE_W     = 15;
    localparam int COUNT_W     = 9;
    localparam int INDEX_W     = 8;
    localparam int SUM_W       = 23;
    localparam int FRAC_BITS   = 8;
    localparam int DIVIDEND_W  = SUM_W + FRAC_BITS;
    localparam int STEP_W      = $clog2(DIVIDEND_W);
    localparam int MAX_ITEMS   = 256;
    localparam int SEG_LIMIT   = 511;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // one closed segment and/or one batch summary
    typedef struct packed {
        logic               has_seg;
        logic               has_sum;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] seg_min;
        logic [INDEX_W-1:0] seg_index;
        logic [COUNT_W-1:0] seg_total;
        logic [VALUE_W-1:0] best_value;
        logic [COUNT_W-1:0] best_position;
        logic               best_seen;
    } sss_job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEG,
        ST_SUM
    } sss_state_t;

endpackage

[design/sss_front.sv]
// ----------------------------------------------------------------------------
// sss_front
// accumulates samples per segment and batch, queues a job on a zero that closes a non-empty segment or on a negative
// ----------------------------------------------------------------------------
module sss_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [sss_pkg::SAMPLE_W-1:0] sample,
    input  logic                         q_full,
    output logic                         push,
    output sss_pkg::sss_job_t            push_job
);
    import sss_pkg::*;

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [VALUE_W-1:0] min_reg, min_next;
    logic [COUNT_W-1:0] done_reg, done_next;
    logic [VALUE_W-1:0] best_reg, best_next;
    logic [COUNT_W-1:0] bpos_reg, bpos_next;
    logic               seen_reg, seen_next;

    logic               accept;
    logic               is_zero;
    logic               is_neg;
    logic               has_items;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] done_inc;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign is_zero   = (sample == '0);
    assign is_neg    = sample[SAMPLE_W-1];
    assign value     = sample[VALUE_W-1:0];
    assign has_items = (count_reg != '0);
    assign done_inc  = (done_reg == COUNT_W'(SEG_LIMIT)) ? done_reg : done_reg + 1'b1;

    assign push = accept && ((is_zero && has_items) || is_neg);

    always_comb
    begin
        push_job               = '0;
        push_job.has_seg       = has_items;
        push_job.has_sum       = is_neg;
        push_job.sum           = sum_reg;
        push_job.count         = count_reg;
        push_job.seg_min       = min_reg;
        push_job.seg_index     = done_reg[INDEX_W-1:0];
        push_job.seg_total     = has_items ? done_inc : done_reg;
        push_job.best_value    = best_reg;
        push_job.best_position = bpos_reg;
        push_job.best_seen     = seen_reg;
    end

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        min_next   = min_reg;
        done_next  = done_reg;
        best_next  = best_reg;
        bpos_next  = bpos_reg;
        seen_next  = seen_reg;
        if (accept)
        begin
            if (is_neg)
            begin
                sum_next   = '0;
                count_next = '0;
                min_next   = '1;
                done_next  = '0;
                best_next  = '0;
                bpos_next  = '0;
                seen_next  = 1'b0;
            end
            else if (is_zero)
            begin
                if (has_items)
                begin
                    sum_next   = '0;
                    count_next = '0;
                    min_next   = '1;
                    done_next  = done_inc;
                end
            end
            else if (count_reg < COUNT_W'(MAX_ITEMS))
            begin
                sum_next   = sum_reg + SUM_W'(value);
                count_next = count_reg + 1'b1;
                if (value < min_reg)
                    min_next = value;
                if (!seen_reg || value > best_reg)
                begin
                    best_next = value;
                    bpos_next = count_reg + 1'b1;
                    seen_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            min_reg   <= '1;
            done_reg  <= '0;
            best_reg  <= '0;
            bpos_reg  <= '0;
            seen_reg  <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            min_reg   <= min_next;
            done_reg  <= done_next;
            best_reg  <= best_next;
            bpos_reg  <= bpos_next;
            seen_reg  <= seen_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_ITEMS))
        else $error("segment count beyond limit");

    a_seen_has_pos: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> bpos_reg != '0)
        else $error("batch maximum without position");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> sum_reg == '0 && min_reg == '1)
        else $error("empty segment holds stale accumulators");

endmodule

[design/sss_queue.sv]
// ----------------------------------------------------------------------------
// sss_queue
// small job queue between the accumulating front and the dividing back
// ----------------------------------------------------------------------------
module sss_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sss_pkg::sss_job_t push_job,
    input  logic              pop,
    output sss_pkg::sss_job_t pop_job,
    output logic              full,
    output logic              empty
);
    import sss_pkg::*;

    sss_job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     cnt_reg, cnt_next;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

[design/sss_back.sv]
// ----------------------------------------------------------------------------
// sss_back
// bit-serial mean division and result formatting into the output register
// ----------------------------------------------------------------------------
module sss_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  sss_pkg::sss_job_t             q_job,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [sss_pkg::INDEX_W-1:0]   segment_index,
    output logic [sss_pkg::SUM_W-1:0]     average_q8,
    output logic [sss_pkg::VALUE_W-1:0]   segment_min,
    output logic [sss_pkg::COUNT_W-1:0]   segment_total,
    output logic [sss_pkg::VALUE_W-1:0]   batch_max,
    output logic [sss_pkg::COUNT_W-1:0]   max_position,
    output logic                          max_valid,
    output logic                          last
);
    import sss_pkg::*;

    sss_state_t state_reg, state_next;

    sss_job_t              job_reg;
    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [COUNT_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg;

    logic                  out_valid_reg;
    logic                  kind_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [SUM_W-1:0]      avg_reg;
    logic [VALUE_W-1:0]    min_reg;
    logic [COUNT_W-1:0]    total_reg;
    logic [VALUE_W-1:0]    max_reg;
    logic [COUNT_W-1:0]    pos_reg;
    logic                  mvalid_reg;
    logic                  last_reg;

    logic                  out_free;
    logic                  div_step;
    logic                  div_done;
    logic                  load_seg;
    logic                  load_sum;
    logic [COUNT_W:0]      rem_shift;
    logic [COUNT_W:0]      rem_diff;
    logic                  quo_bit;

    assign out_free = !out_valid_reg || out_ready;
    assign div_done = (step_reg == STEP_W'(DIVIDEND_W - 1));

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, job_reg.count};
    assign quo_bit   = (rem_shift >= {1'b0, job_reg.count});
    assign rem_next  = quo_bit ? rem_diff[COUNT_W-1:0] : rem_shift[COUNT_W-1:0];
    assign dq_next   = {dq_reg[DIVIDEND_W-2:0], quo_bit};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (!q_empty)
                    state_next = q_job.has_seg ? ST_DIV : ST_SUM;
            ST_DIV:
                if (div_done)
                    state_next = ST_SEG;
            ST_SEG:
                if (out_free)
                    state_next = job_reg.has_sum ? ST_SUM : ST_IDLE;
            ST_SUM:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        div_step = 1'b0;
        load_seg = 1'b0;
        load_sum = 1'b0;
        unique case (state_reg)
            ST_IDLE: pop      = !q_empty;
            ST_DIV:  div_step = 1'b1;
            ST_SEG:  load_seg = out_free;
            ST_SUM:  load_sum = out_free;
            default: pop      = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                step_reg <= '0;
            else if (div_step)
                step_reg <= step_reg + 1'b1;
            if (load_seg || load_sum)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
            dq_reg  <= {q_job.sum, FRAC_BITS'(0)};
            rem_reg <= '0;
        end
        else if (div_step)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
        if (load_seg)
        begin
            kind_reg   <= KIND_SEGMENT;
            index_reg  <= job_reg.seg_index;
            avg_reg    <= dq_reg[SUM_W-1:0];
            min_reg    <= job_reg.seg_min;
            total_reg  <= '0;
            max_reg    <= '0;
            pos_reg    <= '0;
            mvalid_reg <= 1'b0;
            last_reg   <= !job_reg.has_sum;
        end
        else if (load_sum)
        begin
            kind_reg   <= KIND_SUMMARY;
            index_reg  <= '0;
            avg_reg    <= '0;
            min_reg    <= '0;
            total_reg  <= job_reg.seg_total;
            max_reg    <= job_reg.best_seen ? job_reg.best_value : '0;
            pos_reg    <= job_reg.best_seen ? job_reg.best_position : '0;
            mvalid_reg <= job_reg.best_seen;
            last_reg   <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign segment_index = index_reg;
    assign average_q8    = avg_reg;
    assign segment_min   = min_reg;
    assign segment_total = total_reg;
    assign batch_max     = max_reg;
    assign max_position  = pos_reg;
    assign max_valid     = mvalid_reg;
    assign last          = last_reg;

    a_no_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> job_reg.count != '0)
        else $error("division started on an empty segment");

    a_seg_min_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_SEGMENT |-> min_reg != '0)
        else $error("segment result with zero minimum");

    a_empty_batch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_SUMMARY && !mvalid_reg
        |-> max_reg == '0 && pos_reg == '0 && total_reg == '0)
        else $error("empty batch summary carries data");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_SUMMARY |-> last_reg)
        else $error("batch summary not marked last");

endmodule

[design/segmented_stream_statistics_top.sv]
// ----------------------------------------------------------------------------
// segmented_stream_statistics_top
// per-segment mean and minimum, per-batch maximum over a signed sample stream
// ----------------------------------------------------------------------------
// input channel: sample with in_valid / in_ready. a positive sample joins the
// current segment, zero closes it, a negative sample closes it and ends the
// batch. output channel: one result per request with out_valid / out_ready,
// kind 0 for segment statistics and kind 1 for the batch summary.
// the front takes one sample per cycle while the 4-entry job queue has room.
// with the back idle, a segment result passes from its closing sample into
// the queue, is dispatched from the queue, runs through the bit-serial
// restoring divider and is loaded into the output register. a summary alone
// is dispatched from the queue and loaded straight into the output register.
// the divider sets the sustained rate of closed segments: the back takes one
// job at a time, so long segments, whose samples the front keeps taking, hide it.
// a stalled receiver holds the output register; the queue then fills and
// in_ready drops. reset clears all accumulators, the queue and the output
// valid; payload registers are not reset.
// ----------------------------------------------------------------------------
module segmented_stream_statistics_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [sss_pkg::SAMPLE_W-1:0] sample,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               kind,
    output logic [sss_pkg::INDEX_W-1:0]        segment_index,
    output logic [sss_pkg::SUM_W-1:0]          average_q8,
    output logic [sss_pkg::VALUE_W-1:0]        segment_min,
    output logic [sss_pkg::COUNT_W-1:0]        segment_total,
    output logic [sss_pkg::VALUE_W-1:0]        batch_max,
    output logic [sss_pkg::COUNT_W-1:0]        max_position,
    output logic                               max_valid,
    output logic                               last
);
    import sss_pkg::*;

    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;
    sss_job_t push_job;
    sss_job_t pop_job;

    sss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sample   (sample),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    sss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    sss_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_job         (pop_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .segment_index (segment_index),
        .average_q8    (average_q8),
        .segment_min   (segment_min),
        .segment_total (segment_total),
        .batch_max     (batch_max),
        .max_position  (max_position),
        .max_valid     (max_valid),
        .last          (last)
    );

endmodule

[dv/segmented_stream_statistics_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_stream_statistics_top_tb
// drives signed samples through the block and checks every segment and batch
// result against an in-bench prediction of the per-segment mean and minimum
// and the per-batch maximum, with random idling on both channels
// ----------------------------------------------------------------------------
module segmented_stream_statistics_top_tb;
    import sss_pkg::*;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] seg_index;
        logic [SUM_W-1:0]   avg;
        logic [VALUE_W-1:0] seg_min;
        logic [COUNT_W-1:0] seg_total;
        logic [VALUE_W-1:0] top_value;
        logic [COUNT_W-1:0] top_pos;
        logic               top_ok;
        logic               last;
    } stat_result_t;

    localparam int RANDOM_ITEMS   = 100;
    localparam int QUIET_ITEMS    = 30;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;
    localparam int PRINT_LIMIT    = 40;

    class stats_scoreboard;
        stat_result_t       expected[$];
        int unsigned        fail_count;
        int unsigned        result_count;
        bit [SUM_W-1:0]     seg_sum;
        bit [COUNT_W-1:0]   seg_count;
        bit [VALUE_W-1:0]   seg_low;
        bit [COUNT_W-1:0]   seg_done;
        bit [VALUE_W-1:0]   top_value;
        bit [COUNT_W-1:0]   top_pos;
        bit                 top_seen;

        function new();
            clear_batch();
        endfunction

        function void clear_batch();
            seg_sum   = '0;
            seg_count = '0;
            seg_low   = '1;
            seg_done  = '0;
            top_value = '0;
            top_pos   = '0;
            top_seen  = 1'b0;
        endfunction

        function stat_result_t close_segment();
            stat_result_t           r;
            bit [DIVIDEND_W-1:0]    dividend;
            r = '0;
            dividend = DIVIDEND_W'(seg_sum) << FRAC_BITS;
            r.kind      = KIND_SEGMENT;
            r.seg_index = seg_done[INDEX_W-1:0];
            r.avg       = SUM_W'(dividend / DIVIDEND_W'(seg_count));
            r.seg_min   = seg_low;
            if (seg_done != SEG_LIMIT)
                seg_done++;
            seg_sum   = '0;
            seg_count = '0;
            seg_low   = '1;
            return r;
        endfunction

        function void note_sample(sample_t s);
            stat_result_t       r;
            bit [VALUE_W-1:0]   mag;
            mag = s[VALUE_W-1:0];
            if (s == 0) begin
                if (seg_count != 0) begin
                    r = close_segment();
                    r.last = 1'b1;
                    expected.push_back(r);
                end
            end
            else if (!s[SAMPLE_W-1]) begin
                // samples past a full segment are dropped
                if (seg_count < MAX_ITEMS) begin
                    seg_sum += SUM_W'(mag);
                    if (!top_seen || mag > top_value) begin
                        top_value = mag;
                        top_pos   = seg_count + 1'b1;
                        top_seen  = 1'b1;
                    end
                    if (mag < seg_low)
                        seg_low = mag;
                    seg_count++;
                end
            end
            else begin
                if (seg_count != 0) begin
                    r = close_segment();
                    r.last = 1'b0;
                    expected.push_back(r);
                end
                r = '0;
                r.kind      = KIND_SUMMARY;
                r.seg_total = seg_done;
                if (top_seen) begin
                    r.top_value = top_value;
                    r.top_pos   = top_pos;
                    r.top_ok    = 1'b1;
                end
                r.last = 1'b1;
                expected.push_back(r);
                clear_batch();
            end
        endfunction

        task report(string msg);
            if (fail_count < PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
            fail_count++;
        endtask

        task check_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report($sformatf("result %0d %s got %0d want %0d",
                                 result_count, name, got, want));
        endtask

        task check_result(stat_result_t got);
            stat_result_t want;
            if (expected.size() == 0) begin
                report($sformatf("result %0d arrived with nothing pending", result_count));
            end
            else begin
                want = expected.pop_front();
                check_field("kind", got.kind, want.kind);
                check_field("segment_index", got.seg_index, want.seg_index);
                check_field("average_q8", got.avg, want.avg);
                check_field("segment_min", got.seg_min, want.seg_min);
                check_field("segment_total", got.seg_total, want.seg_total);
                check_field("batch_max", got.top_value, want.top_value);
                check_field("max_position", got.top_pos, want.top_pos);
                check_field("max_valid", got.top_ok, want.top_ok);
                check_field("last", got.last, want.last);
            end
            result_count++;
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    sample_t            sample;
    logic               out_valid;
    logic               out_ready;
    logic               kind;
    logic [INDEX_W-1:0] segment_index;
    logic [SUM_W-1:0]   average_q8;
    logic [VALUE_W-1:0] segment_min;
    logic [COUNT_W-1:0] segment_total;
    logic [VALUE_W-1:0] batch_max;
    logic [COUNT_W-1:0] max_position;
    logic               max_valid;
    logic               last;

    stats_scoreboard    board = new();
    bit                 quiet;
    int                 ready_hold;
    int                 stall_cycles;
    int                 samples_sent;

    sample_t opening_run[$] = {
        16'sd0, -16'sd1,
        16'sd32767, 16'sd1, 16'sd0,
        16'sd0,
        16'sd5, 16'sd5, 16'sd3, 16'sh8000,
        16'sd1, 16'sd0,
        16'sd7, 16'sd9, 16'sd9, 16'sd2, -16'sd5,
        16'sd32767, 16'sd32767, 16'sd32767, 16'sd0, -16'sd1
    };

    segmented_stream_statistics_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .segment_index (segment_index),
        .average_q8    (average_q8),
        .segment_min   (segment_min),
        .segment_total (segment_total),
        .batch_max     (batch_max),
        .max_position  (max_position),
        .max_valid     (max_valid),
        .last          (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                board.note_sample(sample);
            if (out_valid && out_ready)
                board.check_result({kind, segment_index, average_q8, segment_min,
                                    segment_total, batch_max, max_position,
                                    max_valid, last});
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (quiet) begin
            out_ready <= 1'b1;
        end
        else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end
        else if (out_ready && $urandom_range(0, 3) == 0) begin
            out_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 16);
        end
        else begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 24);
        end
    end

    function automatic sample_t pick_positive();
        case ($urandom_range(0, 5))
            0:       return sample_t'($urandom_range(1, 4));
            1:       return sample_t'(16'h7FFF);
            default: return sample_t'($urandom_range(1, 32767));
        endcase
    endfunction

    function automatic sample_t pick_negative();
        return sample_t'(16'h8000 | $urandom_range(0, 16'h7FFF));
    endfunction

    // starts and ends at a falling edge
    task automatic send(input sample_t value);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        samples_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (board.expected.size() != 0);
    endtask

    task automatic run_batch();
        int segs;
        int len;
        segs = $urandom_range(0, 6);
        for (int s = 0; s < segs; s++) begin
            if ($urandom_range(0, 24) == 0)
                len = $urandom_range(MAX_ITEMS - 6, MAX_ITEMS + 6);
            else
                len = $urandom_range(0, 8);
            repeat (len) send(pick_positive());
            // the terminator may close the last segment on its own
            if (s != segs - 1 || $urandom_range(0, 1) == 0)
                send(sample_t'(0));
            if ($urandom_range(0, 7) == 0)
                send(sample_t'(0));
        end
        send(pick_negative());
    endtask

    initial
    begin
        int first;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample    = '0;
        out_ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening_run[i])
            send(opening_run[i]);
        drain();

        // a ramp past a full segment, whose late larger samples must be
        // dropped, then enough single-sample segments in the same batch to
        // wrap the index and saturate the count
        for (int k = 1; k <= MAX_ITEMS + 6; k++)
            send(sample_t'(k));
        send(sample_t'(0));
        repeat (SEG_LIMIT) begin
            send(pick_positive());
            send(sample_t'(0));
        end
        send(pick_negative());
        drain();

        first = samples_sent;
        while (samples_sent - first < RANDOM_ITEMS) begin
            if (samples_sent - first > RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 12))
                    send(sample_t'($urandom_range(0, 16'hFFFF)));
            else
                run_batch();
            if ($urandom_range(0, 29) == 0)
                drain();
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (board.fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
design/sss_pkg.sv
design/sss_front.sv
design/sss_queue.sv
design/sss_back.sv
design/segmented_stream_statistics_top.sv
dv/segmented_stream_statistics_top_tb.sv
